// File: src/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// shared constants and types for the curve index-to-point unit
// ----------------------------------------------------------------------------
package sfc_pkg;
    localparam int MAX_DIMS       = 16;
    localparam int AXIS_W         = 4;
    localparam int COORD_W        = 33;
    localparam int POS_W          = 64;
    localparam int CFG_W          = 5;
    localparam int MAX_TOTAL_BITS = 48;

    localparam logic [0:0] REG_DIMS   = 1'b0;
    localparam logic [0:0] REG_LEVELS = 1'b1;

    typedef logic signed [34:0] t_acc;

    // control passed from the level engine to the output stage
    typedef struct packed {
        logic              start;
        logic [AXIS_W-1:0] last_axis;
    } t_emit_ctl;
endpackage

// File: src/sfc_level_engine.sv
// ----------------------------------------------------------------------------
// sfc_level_engine
// walks the curve levels one per step, walking each digit bit serially
// ----------------------------------------------------------------------------
module sfc_level_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [63:0]                 i_x63,
    input  logic [4:0]                  i_n,
    input  logic [4:0]                  i_m,
    input  logic                        i_out_free,
    output logic                        o_busy,
    output sfc_pkg::t_emit_ctl          o_emit,
    output sfc_pkg::t_acc               o_y [sfc_pkg::MAX_DIMS]
);
    import sfc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BITS = 3'd1;
    localparam logic [2:0] S_APPL = 3'd2;
    localparam logic [2:0] S_TERM = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;

    logic [2:0]  r_st, n_st;
    logic [63:0] r_d;          // scaled parameter, shifted left one bit per cycle while digit bits are collected
    logic [4:0]  r_n, r_m;
    logic [4:0]  r_lvl;
    logic [4:0]  r_bi;         // bit index in the current digit
    logic [15:0] r_s;          // digit value collected so far
    // serial cube_node state
    logic        r_prev;       // 1 means previous bit was set
    logic [15:0] r_eu, r_ev;   // 1 means +1
    logic [3:0]  r_axis;
    logic [1:0]  r_kind;       // 0 none, 1 plus, 2 minus
    logic [15:0] r_w;          // 1 means -1
    logic [3:0]  r_it, r_k;
    logic        r_ktop;       // last digit was all ones
    logic [15:0] r_eulast;     // applied entry signs of the last level
    t_acc        r_y [MAX_DIMS];

    logic        bit_v;
    logic [15:0] top;
    logic [15:0] eu_s, ev_s;
    logic [3:0]  ax_s;
    logic [15:0] eu_f, ev_f;

    // digits start just below the integer bit
    assign bit_v = r_d[62];
    assign top   = 16'((17'(1) << r_n) - 17'd1);

    // last-level leftover term: bits after the used digits, rounded
    logic [63:0] frac;
    logic [63:0] term;
    assign frac = {1'b0, r_d[62:0]};
    assign term = (frac + (64'(1) << (6'd30 + 6'(r_m)))) >> (6'd31 + 6'(r_m));

    always_comb begin
        // finalize cube node for the digit in r_s
        eu_s = r_eu;
        ev_s = r_ev;
        ax_s = r_axis;
        if (r_s == 16'd0) begin
            eu_s = '0; ev_s = '0; ax_s = 4'(r_n - 5'd1);
        end else if (r_s == top) begin
            eu_s = 16'd1; ev_s = 16'd1;
            ev_s[4'(r_n - 5'd1)] = 1'b1;
            ax_s = 4'(r_n - 5'd1);
        end else begin
            if (r_kind == 2'd2) ev_s[r_axis] = ~ev_s[r_axis];
            else if (r_kind == 2'd0) ev_s[r_axis] = 1'b0;
            ev_s[4'(r_n - 5'd1)] = ~ev_s[4'(r_n - 5'd1)];
        end
        // swap entries 0 and it
        eu_f = eu_s;
        ev_f = ev_s;
        eu_f[0] = eu_s[r_it]; eu_f[r_it] = eu_s[0];
        ev_f[0] = ev_s[r_it]; ev_f[r_it] = ev_s[0];
    end

    logic [3:0] ax_sw;
    always_comb begin
        if (ax_s == 4'd0) ax_sw = r_it;
        else if (ax_s == r_it) ax_sw = 4'd0;
        else ax_sw = ax_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_start) n_st = S_BITS;
            S_BITS: if (r_bi == r_n - 5'd1) n_st = S_APPL;
            S_APPL: n_st = (r_lvl == r_m - 5'd1) ? S_TERM : S_BITS;
            S_TERM: n_st = S_WAIT;
            S_WAIT: if (i_out_free) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // digit collected from the top, one bit per cycle
    logic [15:0] s_full;
    assign s_full = {r_s[14:0], bit_v};

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_d    <= i_x63 - (i_x63 >> (6'(i_n) * 6'(i_m)));
                r_n    <= i_n;
                r_m    <= i_m;
                r_lvl  <= '0;
                r_bi   <= '0;
                r_s    <= '0;
                r_w    <= '0;
                r_it   <= '0;
                r_k    <= '0;
                r_ktop <= 1'b0;
                for (int i = 0; i < MAX_DIMS; i++) r_y[i] <= '0;
            end
            S_BITS: begin
                r_d  <= r_d << 1;
                r_s  <= s_full;
                r_bi <= r_bi + 5'd1;
            end
            S_APPL: begin
                r_bi <= '0;
                r_lvl <= r_lvl + 5'd1;
                if (r_kind == 2'd1 || (r_kind == 2'd0 && r_s == 16'd0)) r_k <= ax_sw;
                else if (r_kind == 2'd2) r_k <= (r_it == 4'(r_n - 5'd1)) ? 4'd0
                                                 : 4'(r_n - 5'd1);
                r_it <= ax_sw;
                r_ktop <= (r_s == top);
                for (int i = 0; i < MAX_DIMS; i++) begin
                    logic e;
                    e = eu_f[i] ^ r_w[i];
                    r_eulast[i] <= e;
                    if (i < 32'(r_n)) begin
                        if (e) r_y[i] <= r_y[i] + t_acc'(64'sd1 <<< (5'd30 - r_lvl));
                        else   r_y[i] <= r_y[i] - t_acc'(64'sd1 <<< (5'd30 - r_lvl));
                        r_w[i] <= r_w[i] ^ ev_f[i];
                    end
                end
                r_s <= '0;
            end
            S_TERM: begin
                if (r_eulast[r_k] ^ r_ktop) r_y[r_k] <= r_y[r_k] - t_acc'(term);
                else                        r_y[r_k] <= r_y[r_k] + t_acc'(term);
            end
            default: ;
        endcase
    end

    // serial node decode, one bit per cycle while the digit streams in
    // the key axis sits at the last place where the digit bits change value
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE || r_st == S_APPL) begin
            r_prev <= 1'b0; r_kind <= 2'd0; r_axis <= '0;
            r_eu <= '0; r_ev <= '0;
        end else if (r_st == S_BITS) begin
            r_eu[r_bi[3:0]] <= r_prev ^ bit_v;
            r_ev[r_bi[3:0]] <= r_prev ^ bit_v;
            if (r_bi != 5'd0 && bit_v != r_prev) begin
                r_axis <= 4'(r_bi - 5'd1);
                r_kind <= r_prev ? 2'd2 : 2'd1;
            end
            r_prev <= bit_v;
        end
    end

    assign o_busy = (r_st != S_IDLE);
    assign o_emit.start = (r_st == S_WAIT) && i_out_free;
    assign o_emit.last_axis = 4'(r_n - 5'd1);
    always_comb for (int i = 0; i < MAX_DIMS; i++) o_y[i] = r_y[i];
endmodule

// File: src/sfc_emitter.sv
// ----------------------------------------------------------------------------
// sfc_emitter
// shifts coordinates out one per transfer, saturating each
// ----------------------------------------------------------------------------
module sfc_emitter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfc_pkg::t_emit_ctl            i_emit,
    input  sfc_pkg::t_acc                 i_y [sfc_pkg::MAX_DIMS],
    input  sfc_pkg::t_acc                 i_single_y,
    input  logic                          i_single_go,
    input  logic                          i_stall,
    output logic                          o_free,
    output logic                          o_valid,
    output logic signed [sfc_pkg::COORD_W-1:0] o_coordinate,
    output logic [sfc_pkg::AXIS_W-1:0]    o_axis,
    output logic                          o_last
);
    import sfc_pkg::*;

    t_acc              r_q [MAX_DIMS];
    logic              r_v;
    logic [AXIS_W-1:0] r_ax, r_lastax;

    function automatic logic signed [COORD_W-1:0] sat(input t_acc v);
        if (v > t_acc'(64'sd2147483648))       sat = 33'sd2147483648;
        else if (v < -t_acc'(64'sd2147483648)) sat = -33'sd2147483648;
        else                                    sat = v[COORD_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_emit.start || i_single_go) begin
            r_v <= 1'b1;
        end else if (r_v && !i_stall && r_ax == r_lastax) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.start) begin
            for (int i = 0; i < MAX_DIMS; i++) r_q[i] <= i_y[i];
            r_ax <= '0;
            r_lastax <= i_emit.last_axis;
        end else if (i_single_go) begin
            r_q[0] <= i_single_y;
            r_ax <= '0;
            r_lastax <= '0;
        end else if (r_v && !i_stall) begin
            for (int i = 0; i < MAX_DIMS - 1; i++) r_q[i] <= r_q[i+1];
            r_ax <= r_ax + AXIS_W'(1);
        end
    end

    assign o_free       = !r_v;
    assign o_valid      = r_v;
    assign o_coordinate = sat(r_q[0]);
    assign o_axis       = r_ax;
    assign o_last       = (r_ax == r_lastax);
endmodule

// File: src/space_filling_curve_index_to_point_unit.sv
// ----------------------------------------------------------------------------
// space_filling_curve_index_to_point_unit
// maps a curve position to a point of the centered unit hypercube
// ----------------------------------------------------------------------------
// channel | direction | handshake      | payload
// in      | input     | valid / stall  | position
// out     | output    | valid / stall  | coordinate, axis, last
// cfg     | input     | valid / ready  | index, data (dims, levels)
//
// per item: each level collects its digit bit by bit, one bit per dimension, then
// applies it; after the last level the leftover term is added and the point
// waits for a free output; a single dimension skips the level walk
// one item at a time; a new position is taken once the previous point is out
// reset loads dims = 2, levels = 10; output stall holds the current coordinate
module space_filling_curve_index_to_point_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [sfc_pkg::POS_W-1:0]          i_position,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [sfc_pkg::COORD_W-1:0] o_coordinate,
    output logic [sfc_pkg::AXIS_W-1:0]         o_axis,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [0:0]                         i_cfg_index,
    input  logic [sfc_pkg::CFG_W-1:0]          i_cfg_data
);
    import sfc_pkg::*;

    logic [4:0] r_dims, r_levels;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims   <= 5'd2;
            r_levels <= 5'd10;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DIMS:   r_dims   <= i_cfg_data;
                REG_LEVELS: r_levels <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // clamp dims and levels
    logic [4:0] n_eff, m_eff, m_max;
    always_comb begin
        n_eff = (r_dims == 5'd0) ? 5'd1 : (r_dims > 5'd16) ? 5'd16 : r_dims;
        unique case (n_eff)
            5'd2: m_max = 5'd24;  5'd3: m_max = 5'd16;  5'd4: m_max = 5'd12;
            5'd5: m_max = 5'd9;   5'd6: m_max = 5'd8;   5'd7: m_max = 5'd6;
            5'd8: m_max = 5'd6;   5'd9: m_max = 5'd5;   5'd10: m_max = 5'd4;
            5'd11: m_max = 5'd4;  5'd12: m_max = 5'd4;  5'd13: m_max = 5'd3;
            5'd14: m_max = 5'd3;  5'd15: m_max = 5'd3;  5'd16: m_max = 5'd3;
            default: m_max = 5'd24;
        endcase
        m_eff = (r_levels == 5'd0) ? 5'd1 : (r_levels > m_max) ? m_max : r_levels;
    end

    // saturate position at full scale
    logic [63:0] x63;
    assign x63 = (i_position > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000
                                                         : i_position;

    logic      busy, out_free, take;
    t_emit_ctl emit;
    t_acc      y [MAX_DIMS];
    t_acc      single_y;

    assign o_stall = busy || !out_free;
    assign take    = i_valid && !o_stall;

    // single dimension: x - 0.5 rounded
    assign single_y = t_acc'((x63 + 64'(1 << 30)) >> 31) - t_acc'(64'sd2147483648);

    sfc_level_engine u_eng (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (take && n_eff != 5'd1),
        .i_x63      (x63),
        .i_n        (n_eff),
        .i_m        (m_eff),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_emit     (emit),
        .o_y        (y)
    );

    sfc_emitter u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_emit       (emit),
        .i_y          (y),
        .i_single_y   (single_y),
        .i_single_go  (take && n_eff == 5'd1),
        .i_stall      (i_stall),
        .o_free       (out_free),
        .o_valid      (o_valid),
        .o_coordinate (o_coordinate),
        .o_axis       (o_axis),
        .o_last       (o_last)
    );

    // no new position while a point is in flight
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> o_stall) else $error("input taken while busy");
    // a result never appears during the level walk
    a_no_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !emit.start && $past(busy)) |-> !($rose(o_valid)))
        else $error("output while walking");
    // stalled output holds its coordinate
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_coordinate) && $stable(o_axis))
        else $error("output changed under stall");
endmodule
